>>> rtl/adg_pkg.sv
`default_nettype none

package adg_pkg;

    localparam int COORD_W = 24;
    localparam int TAG_W   = 6;

    localparam logic OP_ANCHOR = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] CFG_SCORE_THR   = 2'd0;
    localparam logic [1:0] CFG_OVERLAP_THR = 2'd1;
    localparam logic [1:0] CFG_UNSCALE     = 2'd2;

    localparam logic [1:0] LEVEL_NONE = 2'd3;

    localparam logic [15:0] SCORE_THR_RST   = 16'd32768;
    localparam logic [15:0] OVERLAP_THR_RST = 16'd26214;
    localparam logic [19:0] UNSCALE_RST     = 20'd4096;

    localparam logic [2:0] CONV_LEFT   = 3'd1;
    localparam logic [2:0] CONV_TOP    = 3'd2;
    localparam logic [2:0] CONV_WIDTH  = 3'd3;
    localparam logic [2:0] CONV_HEIGHT = 3'd4;

    typedef struct packed {
        logic               opcode;
        logic [1:0]         level;
        logic [13:0]        anchor_index;
        logic [15:0]        score;
        logic signed [15:0] dist_left;
        logic signed [15:0] dist_top;
        logic signed [15:0] dist_right;
        logic signed [15:0] dist_bottom;
    } in_item_t;

    typedef struct packed {
        logic                      face_valid;
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic signed [COORD_W-1:0] box_width;
        logic signed [COORD_W-1:0] box_height;
        logic [15:0]               face_score;
        logic                      store_overflowed;
        logic                      last;
    } out_item_t;

    typedef struct packed {
        logic [15:0]               score;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } cand_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } iou_req_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [TAG_W-1:0] tag;
    } iou_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEC_CELL,
        ST_DEC_ROW,
        ST_DEC_WRITE,
        ST_SEARCH,
        ST_PUSH,
        ST_REF_RD,
        ST_REF_CAP,
        ST_CONV,
        ST_SUPP,
        ST_FLUSH
    } state_t;

    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd8388607;
        lo = -40'sd8388608;
        if (v > hi)
        begin
            return hi[COORD_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/adg_iou.sv
`default_nettype none

module adg_iou
    import adg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [15:0]        overlap_thr,
    input  wire cand_t              ref_box,
    input  wire logic signed [49:0] ref_area,
    input  wire iou_req_t           req,
    input  wire cand_t              req_box,
    output iou_res_t                res,
    output logic                    busy
);

    // stage 1: intersection extents and candidate size
    logic             s1_v_reg;
    logic [TAG_W-1:0] s1_tag_reg;
    logic [23:0]      s1_iw_reg, s1_ih_reg;
    logic signed [24:0] s1_bw_reg, s1_bh_reg;
    // stage 2: products
    logic             s2_v_reg;
    logic [TAG_W-1:0] s2_tag_reg;
    logic [47:0]      s2_inter_reg;
    logic signed [49:0] s2_area_reg;
    // stage 3: union
    logic             s3_v_reg;
    logic [TAG_W-1:0] s3_tag_reg;
    logic [47:0]      s3_inter_reg;
    logic signed [51:0] s3_uni_reg;
    // stage 4: union times threshold in two halves
    logic             s4_v_reg;
    logic [TAG_W-1:0] s4_tag_reg;
    logic [47:0]      s4_inter_reg;
    logic             s4_pos_reg;
    logic [40:0]      s4_plo_reg, s4_phi_reg;
    iou_res_t         res_reg;

    logic signed [COORD_W-1:0] ix1, iy1, ix2, iy2;
    logic signed [24:0] iw, ih;
    logic [23:0]        iw_c, ih_c;
    logic signed [51:0] uni_next;
    logic [49:0]        uni_u;
    logic [65:0]        rhs;
    logic [65:0]        lhs;

    assign ix1 = (ref_box.x1 > req_box.x1) ? ref_box.x1 : req_box.x1;
    assign iy1 = (ref_box.y1 > req_box.y1) ? ref_box.y1 : req_box.y1;
    assign ix2 = (ref_box.x2 < req_box.x2) ? ref_box.x2 : req_box.x2;
    assign iy2 = (ref_box.y2 < req_box.y2) ? ref_box.y2 : req_box.y2;
    assign iw  = 25'(ix2) - 25'(ix1);
    assign ih  = 25'(iy2) - 25'(iy1);
    assign iw_c = iw[24] ? 24'd0 : iw[23:0];
    assign ih_c = ih[24] ? 24'd0 : ih[23:0];

    assign uni_next = $signed({{2{ref_area[49]}}, ref_area})
                    + $signed({{2{s2_area_reg[49]}}, s2_area_reg})
                    - $signed({4'b0, s2_inter_reg});
    assign uni_u = s3_uni_reg[49:0];
    assign rhs = {s4_phi_reg, 25'b0} + {25'b0, s4_plo_reg};
    assign lhs = {2'b0, s4_inter_reg, 16'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            s1_v_reg <= req.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            res_reg.valid <= s4_v_reg;
            res_reg.tag   <= s4_tag_reg;
            res_reg.hit   <= s4_pos_reg && (lhs > rhs);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg   <= req.tag;
        s1_iw_reg    <= iw_c;
        s1_ih_reg    <= ih_c;
        s1_bw_reg    <= 25'(req_box.x2) - 25'(req_box.x1);
        s1_bh_reg    <= 25'(req_box.y2) - 25'(req_box.y1);
        s2_tag_reg   <= s1_tag_reg;
        s2_inter_reg <= s1_iw_reg * s1_ih_reg;
        s2_area_reg  <= s1_bw_reg * s1_bh_reg;
        s3_tag_reg   <= s2_tag_reg;
        s3_inter_reg <= s2_inter_reg;
        s3_uni_reg   <= uni_next;
        s4_tag_reg   <= s3_tag_reg;
        s4_inter_reg <= s3_inter_reg;
        s4_pos_reg   <= (s3_uni_reg > 52'sd0);
        s4_plo_reg   <= uni_u[24:0] * overlap_thr;
        s4_phi_reg   <= uni_u[49:25] * overlap_thr;
    end

    assign res  = res_reg;
    assign busy = s1_v_reg | s2_v_reg | s3_v_reg | s4_v_reg | res_reg.valid;

endmodule

`default_nettype wire

>>> rtl/anchor_decode_greedy_nms.sv
`default_nettype none

// Anchor decode with greedy non-maximum suppression. An anchor transaction
// passes acceptance and three decode steps (cell, row, corner write into
// the candidate memory). A finish transaction handles one survivor at a
// time: one scan of the candidate memory finds the best remaining score,
// one more scan feeds the overlap pipeline, and the box is rescaled
// through a single shared multiplier. The candidate memory has a single
// read port. The input is stalled while a transaction is in work; one
// result register decouples the output.
module anchor_decode_greedy_nms
    import adg_pkg::*;
#(
    parameter int MAX_CAND         = 64,
    parameter int NET_SIZE         = 640,
    parameter int ANCHORS_PER_CELL = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data
);

    localparam int CNT_W    = $clog2(MAX_CAND + 1);
    localparam int IDX_W    = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
    localparam int RECIP_SH = 16;
    localparam int FW0      = (NET_SIZE / 8 < 1) ? 1 : NET_SIZE / 8;
    localparam int FW1      = (NET_SIZE / 16 < 1) ? 1 : NET_SIZE / 16;
    localparam int FW2      = (NET_SIZE / 32 < 1) ? 1 : NET_SIZE / 32;
    localparam int RA       = (1 << RECIP_SH) / ANCHORS_PER_CELL;
    localparam int R0       = (1 << RECIP_SH) / FW0;
    localparam int R1       = (1 << RECIP_SH) / FW1;
    localparam int R2       = (1 << RECIP_SH) / FW2;

    state_t state_reg, state_next;

    logic [15:0] score_thr_reg;
    logic [15:0] overlap_thr_reg;
    logic [19:0] unscale_reg;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [MAX_CAND-1:0] done_reg, done_next;

    in_item_t    item_reg;
    logic        item_load;
    logic [13:0] cell_reg, row_reg;

    cand_t mem [MAX_CAND];
    cand_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    cand_t            wr_data;

    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             pv_reg, pv_next;
    logic [IDX_W-1:0] ptag_reg, ptag_next;
    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [15:0]      best_score_reg, best_score_next;

    cand_t              ref_reg;
    logic               ref_load;
    logic signed [49:0] area_reg;
    logic [2:0]         conv_reg, conv_next;
    logic signed [45:0] prod_reg;

    out_item_t pend_reg, pend_next;
    logic      pend_valid_reg, pend_valid_next;

    logic      out_valid_reg;
    out_item_t out_data_reg, out_next;
    logic      out_load;
    logic      slot_free;

    iou_req_t iou_req;
    iou_res_t iou_res;
    logic     iou_busy;

    // anchor decode arithmetic
    logic [30:0] cell_prod;
    logic [13:0] cell_est, cell_fix;
    logic [16:0] cell_back;
    logic [7:0]  fw_sel;
    logic [16:0] recip_sel;
    logic [30:0] row_prod;
    logic [21:0] row_back, col_diff, col_adj;
    logic        col_wrap;
    logic [13:0] row_fix;
    logic [3:0]  shamt;
    logic [27:0] cx, cy;
    logic signed [27:0] dl_s, dt_s, dr_s, db_s;
    logic signed [27:0] x1_s, y1_s, x2_s, y2_s;

    // rescale arithmetic
    logic signed [24:0] conv_op;
    logic signed [45:0] conv_prod, rounded;
    logic signed [COORD_W-1:0] conv_val;
    logic signed [24:0] ref_aw, ref_ah;

    assign cell_prod = 31'(item_reg.anchor_index) * 31'(RA);
    assign cell_est  = cell_prod[RECIP_SH +: 14];
    assign cell_back = 17'(cell_est) * 17'(ANCHORS_PER_CELL);
    assign cell_fix  = ((17'(item_reg.anchor_index) - cell_back) >= 17'(ANCHORS_PER_CELL))
                     ? cell_est + 14'd1 : cell_est;

    always_comb
    begin
        case (item_reg.level)
            2'd0:
            begin
                fw_sel    = 8'(FW0);
                recip_sel = 17'(R0);
            end
            2'd1:
            begin
                fw_sel    = 8'(FW1);
                recip_sel = 17'(R1);
            end
            default:
            begin
                fw_sel    = 8'(FW2);
                recip_sel = 17'(R2);
            end
        endcase
    end

    assign row_prod = 31'(cell_reg) * 31'(recip_sel);
    assign row_back = 22'(row_reg) * 22'(fw_sel);
    assign col_diff = 22'(cell_reg) - row_back;
    assign col_wrap = (col_diff >= 22'(fw_sel));
    assign col_adj  = col_wrap ? col_diff - 22'(fw_sel) : col_diff;
    assign row_fix  = col_wrap ? row_reg + 14'd1 : row_reg;

    // stride * 32 in Q.5 is 256 << level
    assign shamt = 4'd8 + {2'b0, item_reg.level};
    assign cx    = 28'(col_adj[7:0]) << shamt;
    assign cy    = 28'(row_fix) << shamt;
    assign dl_s  = 28'(item_reg.dist_left) <<< item_reg.level;
    assign dt_s  = 28'(item_reg.dist_top) <<< item_reg.level;
    assign dr_s  = 28'(item_reg.dist_right) <<< item_reg.level;
    assign db_s  = 28'(item_reg.dist_bottom) <<< item_reg.level;
    assign x1_s  = $signed(cx) - dl_s;
    assign y1_s  = $signed(cy) - dt_s;
    assign x2_s  = $signed(cx) + dr_s;
    assign y2_s  = $signed(cy) + db_s;

    assign wr_data.score = item_reg.score;
    assign wr_data.x1    = sat24({{12{x1_s[27]}}, x1_s});
    assign wr_data.y1    = sat24({{12{y1_s[27]}}, y1_s});
    assign wr_data.x2    = sat24({{12{x2_s[27]}}, x2_s});
    assign wr_data.y2    = sat24({{12{y2_s[27]}}, y2_s});

    assign ref_aw = 25'(ref_reg.x2) - 25'(ref_reg.x1);
    assign ref_ah = 25'(ref_reg.y2) - 25'(ref_reg.y1);

    always_comb
    begin
        case (conv_reg)
            3'd0:    conv_op = 25'(ref_reg.x1);
            3'd1:    conv_op = 25'(ref_reg.y1);
            3'd2:    conv_op = ref_aw;
            3'd3:    conv_op = ref_ah;
            default: conv_op = '0;
        endcase
    end

    // Q.5 times Q8.12 gives Q.17; round half up into Q.4
    assign conv_prod = conv_op * $signed({1'b0, unscale_reg});
    assign rounded   = prod_reg + 46'sd4096;
    assign conv_val  = sat24({{7{rounded[45]}}, rounded[45:13]});

    assign slot_free = !out_valid_reg || !out_stall;

    assign iou_req.valid = (state_reg == ST_SUPP) && pv_reg;
    assign iou_req.tag   = TAG_W'(ptag_reg);

    adg_iou u_iou (
        .clk         (clk),
        .rst_n       (rst_n),
        .overlap_thr (overlap_thr_reg),
        .ref_box     (ref_reg),
        .ref_area    (area_reg),
        .req         (iou_req),
        .req_box     (rd_data_reg),
        .res         (iou_res),
        .busy        (iou_busy)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        done_next       = done_reg;
        item_load       = 1'b0;
        mem_we          = 1'b0;
        rd_addr         = scan_reg[IDX_W-1:0];
        scan_next       = scan_reg;
        pv_next         = 1'b0;
        ptag_next       = ptag_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_score_next = best_score_reg;
        ref_load        = 1'b0;
        conv_next       = conv_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_load        = 1'b0;
        out_next        = out_data_reg;

        if (iou_res.valid && iou_res.hit)
        begin
            done_next[iou_res.tag[IDX_W-1:0]] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.opcode == OP_FINISH)
                    begin
                        scan_next       = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SEARCH;
                    end
                    else if (in_data.level != LEVEL_NONE && in_data.score >= score_thr_reg)
                    begin
                        if (cnt_reg >= CNT_W'(MAX_CAND))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            item_load  = 1'b1;
                            state_next = ST_DEC_CELL;
                        end
                    end
                end
            end
            ST_DEC_CELL:
            begin
                state_next = ST_DEC_ROW;
            end
            ST_DEC_ROW:
            begin
                state_next = ST_DEC_WRITE;
            end
            ST_DEC_WRITE:
            begin
                mem_we     = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (scan_reg < cnt_reg)
                begin
                    pv_next   = 1'b1;
                    ptag_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                // strict compare keeps the earliest of equal scores
                if (pv_reg && !done_reg[ptag_reg]
                    && (!best_found_reg || rd_data_reg.score > best_score_reg))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = ptag_reg;
                    best_score_next = rd_data_reg.score;
                end
                if (scan_reg == cnt_reg && !pv_reg)
                begin
                    if (best_found_reg)
                    begin
                        done_next[best_idx_reg] = 1'b1;
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_REF_RD;
                end
                else if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_REF_RD;
                end
            end
            ST_REF_RD:
            begin
                rd_addr    = best_idx_reg;
                state_next = ST_REF_CAP;
            end
            ST_REF_CAP:
            begin
                ref_load   = 1'b1;
                conv_next  = '0;
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                conv_next = conv_reg + 3'd1;
                case (conv_reg)
                    CONV_LEFT:   pend_next.box_left   = conv_val;
                    CONV_TOP:    pend_next.box_top    = conv_val;
                    CONV_WIDTH:  pend_next.box_width  = conv_val;
                    CONV_HEIGHT: pend_next.box_height = conv_val;
                    default:     pend_next.face_score = ref_reg.score;
                endcase
                if (conv_reg == CONV_HEIGHT)
                begin
                    pend_next.face_valid       = 1'b1;
                    pend_next.store_overflowed = ovf_reg;
                    pend_next.last             = 1'b0;
                    pend_valid_next            = 1'b1;
                    scan_next                  = '0;
                    state_next                 = ST_SUPP;
                end
            end
            ST_SUPP:
            begin
                if (scan_reg < cnt_reg)
                begin
                    pv_next   = 1'b1;
                    ptag_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                if (scan_reg == cnt_reg && !pv_reg && !iou_busy)
                begin
                    scan_next       = '0;
                    best_found_next = 1'b0;
                    state_next      = ST_SEARCH;
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next = '0;
                        out_next.store_overflowed = ovf_reg;
                    end
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    ovf_next        = 1'b0;
                    done_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            score_thr_reg   <= SCORE_THR_RST;
            overlap_thr_reg <= OVERLAP_THR_RST;
            unscale_reg     <= UNSCALE_RST;
            cnt_reg         <= '0;
            ovf_reg         <= 1'b0;
            done_reg        <= '0;
            scan_reg        <= '0;
            pv_reg          <= 1'b0;
            best_found_reg  <= 1'b0;
            conv_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            done_reg       <= done_next;
            scan_reg       <= scan_next;
            pv_reg         <= pv_next;
            best_found_reg <= best_found_next;
            conv_reg       <= conv_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_load || (out_valid_reg && out_stall);
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SCORE_THR:   score_thr_reg   <= cfg_data[15:0];
                    CFG_OVERLAP_THR: overlap_thr_reg <= cfg_data[15:0];
                    CFG_UNSCALE:     unscale_reg     <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_DEC_CELL)
        begin
            cell_reg <= cell_fix;
        end
        if (state_reg == ST_DEC_ROW)
        begin
            row_reg <= row_prod[RECIP_SH +: 14];
        end
        if (ref_load)
        begin
            ref_reg <= rd_data_reg;
        end
        if (state_reg == ST_CONV && conv_reg == 3'd0)
        begin
            area_reg <= ref_aw * ref_ah;
        end
        if (out_load)
        begin
            out_data_reg <= out_next;
        end
        prod_reg       <= conv_prod;
        ptag_reg       <= ptag_next;
        best_idx_reg   <= best_idx_next;
        best_score_reg <= best_score_next;
        pend_reg       <= pend_next;
    end

    // candidate memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/adg_checker.sv
`default_nettype none

module adg_checker
    import adg_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

    // an empty result closes the run and carries no box
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.face_valid |-> out_data.last
            && out_data.box_width == '0 && out_data.face_score == '0)
        else $error("empty result malformed");

    // a finish transaction always starts a run that blocks the input
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.opcode == OP_FINISH |=> in_stall)
        else $error("input open right after finish");

endmodule

bind anchor_decode_greedy_nms adg_checker u_adg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
